// File: hw/rtl/glmd_pkg.sv
// ----------------------------------------------------------------------------
// glmd_pkg
// Shared types, limits and helpers of the grid local minimum detector.
// ----------------------------------------------------------------------------
package glmd_pkg;

  // Matrix size limits
  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;

  localparam logic [5:0] ROW_CAP = 6'((MAX_ROWS < 32) ? MAX_ROWS : 32);
  localparam logic [5:0] COL_CAP = 6'((MAX_COLS < 32) ? MAX_COLS : 32);

  // Line memory geometry: one entry per column, two stacked rows per entry
  localparam int LINE_DEPTH = int'(COL_CAP);
  localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int VAL_W      = 32;
  localparam int LINE_W     = 2 * VAL_W;

  // Output queue depth (room for two results per column beat)
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = OQ_AW + 1;

  // Configuration register indexes
  localparam int          CFG_IDX_W     = 2;
  localparam logic [1:0]  REG_ROW_COUNT = 2'd0;
  localparam logic [1:0]  REG_COL_COUNT = 2'd1;

  // Beat waiting on the line memory read
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [4:0]              row;        // row of the cell to classify
    logic [4:0]              col;
    logic                    has_top;
    logic                    flush;      // last-row pass, no write-back
    logic                    emit;
    logic                    last_col;
    logic                    frame_end;
  } issue_t;

  // One 3-high column of the sliding window
  typedef struct packed {
    logic signed [VAL_W-1:0] top;
    logic signed [VAL_W-1:0] ctr;
    logic signed [VAL_W-1:0] bot;
    logic                    has_top;
    logic                    has_bot;
    logic                    emit;
    logic                    last_col;
    logic                    frame_end;
    logic [4:0]              row;
    logic [4:0]              col;
  } col_t;

  // One classified cell
  typedef struct packed {
    logic [4:0]              row;
    logic [4:0]              col;
    logic signed [VAL_W-1:0] value;
    logic                    is_min;
    logic                    frame_end;
  } res_t;

  // Up to two results pushed per window step, first one first
  typedef struct packed {
    logic a_valid;
    res_t a;
    logic b_valid;
    res_t b;
  } push_t;

  // Map a raw count register to its last index, clamped to 1..cap
  function automatic logic [4:0] last_index(input logic [5:0] v, input logic [5:0] cap);
    if (v == 6'd0) begin
      return 5'd0;
    end else if (v > cap) begin
      return 5'(cap - 6'd1);
    end else begin
      return 5'(v - 6'd1);
    end
  endfunction

  // True if h is greater than an existing entry of column c
  function automatic logic beats(input logic signed [VAL_W-1:0] h, input col_t c,
                                 input logic with_ctr);
    return (c.has_top && (h > $signed(c.top))) ||
           (with_ctr  && (h > $signed(c.ctr))) ||
           (c.has_bot && (h > $signed(c.bot)));
  endfunction

endpackage

// File: hw/rtl/glmd_line_mem.sv
// ----------------------------------------------------------------------------
// glmd_line_mem
// Column-indexed line memory holding the two previous rows per entry, with a
// registered read port and write-to-read forwarding for the same entry.
// ----------------------------------------------------------------------------
module glmd_line_mem (
  input  logic                                  clk,
  input  logic                                  rd_en,
  input  logic [glmd_pkg::LINE_AW-1:0]          rd_addr,
  output logic [glmd_pkg::LINE_W-1:0]           rd_data,
  input  logic                                  wr_en,
  input  logic [glmd_pkg::LINE_AW-1:0]          wr_addr,
  input  logic [glmd_pkg::LINE_W-1:0]           wr_data
);

  logic [glmd_pkg::LINE_W-1:0] mem [glmd_pkg::LINE_DEPTH];
  logic [glmd_pkg::LINE_W-1:0] q_r;
  logic [glmd_pkg::LINE_W-1:0] fwd_data_r;
  logic                        fwd_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; hold the data while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  // Take the data written in the read cycle over the stale array value
  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule

// File: hw/rtl/glmd_window.sv
// ----------------------------------------------------------------------------
// glmd_window
// Three-column sliding window that classifies the middle column's center
// cell, and at a row's last column also the newest column's center cell.
// ----------------------------------------------------------------------------
module glmd_window (
  input  logic             clk,
  input  logic             col_valid,
  input  glmd_pkg::col_t   col_in,
  input  logic             room,
  output logic             adv,
  output glmd_pkg::push_t  push
);

  glmd_pkg::col_t p1_r;   // column left of the incoming one
  glmd_pkg::col_t p2_r;   // two columns left

  logic left_a;
  logic left_b;
  logic beat_a;
  logic beat_b;

  assign adv = col_valid && room;

  // Shift the window on every accepted column beat
  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r <= p1_r;
      p1_r <= col_in;
    end
  end

  // Center of the middle column, right neighbor is the incoming column
  assign left_a = (p1_r.col != 5'd0);
  assign beat_a = (left_a && glmd_pkg::beats(p1_r.ctr, p2_r, 1'b1)) ||
                  glmd_pkg::beats(p1_r.ctr, p1_r, 1'b0) ||
                  glmd_pkg::beats(p1_r.ctr, col_in, 1'b1);

  // Center of the incoming last column, no right neighbor
  assign left_b = (col_in.col != 5'd0);
  assign beat_b = (left_b && glmd_pkg::beats(col_in.ctr, p1_r, 1'b1)) ||
                  glmd_pkg::beats(col_in.ctr, col_in, 1'b0);

  // Build the results for this step
  always_comb begin
    push.a_valid     = adv && col_in.emit && (col_in.col != 5'd0);
    push.a.row       = p1_r.row;
    push.a.col       = p1_r.col;
    push.a.value     = p1_r.ctr;
    push.a.is_min    = !beat_a;
    push.a.frame_end = 1'b0;

    push.b_valid     = adv && col_in.emit && col_in.last_col;
    push.b.row       = col_in.row;
    push.b.col       = col_in.col;
    push.b.value     = col_in.ctr;
    push.b.is_min    = !beat_b;
    push.b.frame_end = col_in.frame_end;
  end

endmodule

// File: hw/rtl/glmd_out_fifo.sv
// ----------------------------------------------------------------------------
// glmd_out_fifo
// Small result queue taking up to two beats per cycle and draining one per
// cycle onto the result channel while out_ready is high.
// ----------------------------------------------------------------------------
module glmd_out_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  glmd_pkg::push_t                 push,
  output logic                            room,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [4:0]                      out_cell_row,
  output logic [4:0]                      out_cell_col,
  output logic signed [glmd_pkg::VAL_W-1:0] out_cell_out,
  output logic                            out_is_minimum,
  output logic                            out_frame_end
);

  glmd_pkg::res_t                 q_mem [glmd_pkg::OQ_DEPTH];
  logic [glmd_pkg::OQ_AW-1:0]     wptr_r, wptr_nxt;
  logic [glmd_pkg::OQ_AW-1:0]     rptr_r, rptr_nxt;
  logic [glmd_pkg::OQ_CW-1:0]     count_r, count_nxt;
  logic [glmd_pkg::OQ_AW-1:0]     b_addr;
  logic [glmd_pkg::OQ_CW-1:0]     n_push;
  logic                           pop;

  assign room      = (count_r <= glmd_pkg::OQ_CW'(glmd_pkg::OQ_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign b_addr    = push.a_valid ? (wptr_r + glmd_pkg::OQ_AW'(1)) : wptr_r;
  assign n_push    = glmd_pkg::OQ_CW'(push.a_valid) + glmd_pkg::OQ_CW'(push.b_valid);

  // Store pushed results in order
  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      q_mem[wptr_r] <= push.a;
    end
    if (push.b_valid) begin
      q_mem[b_addr] <= push.b;
    end
  end

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt  = wptr_r + glmd_pkg::OQ_AW'(n_push);
    rptr_nxt  = pop ? (rptr_r + glmd_pkg::OQ_AW'(1)) : rptr_r;
    count_nxt = count_r + n_push - glmd_pkg::OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Present the head beat
  assign out_cell_row   = q_mem[rptr_r].row;
  assign out_cell_col   = q_mem[rptr_r].col;
  assign out_cell_out   = q_mem[rptr_r].value;
  assign out_is_minimum = q_mem[rptr_r].is_min;
  assign out_frame_end  = q_mem[rptr_r].frame_end;

endmodule

// File: hw/rtl/grid_local_minimum_detector.sv
// ----------------------------------------------------------------------------
// grid_local_minimum_detector
// Classifies each cell of a raster matrix stream as a 3x3 local minimum.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | in_cell_value
//   out     | output    | out_valid/out_ready| out_cell_row, out_cell_col,
//           |           |                    | out_cell_out, out_is_minimum,
//           |           |                    | out_frame_end
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One cell is taken per cycle unless stalled; results pass s1, s2 and the
// output queue after the cell completing their neighborhood. The frame's
// final cell starts a last-row pass reading the line memory one column per
// cycle unless stalled; input stalls until the pass ends. Reset clears the
// position, pass and queue and sets both counts to 32; line memory is kept.
// Result stalls back up via a four-entry queue into the line memory stages.
// ----------------------------------------------------------------------------
module grid_local_minimum_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [glmd_pkg::VAL_W-1:0]   in_cell_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [4:0]                          out_cell_row,
  output logic [4:0]                          out_cell_col,
  output logic signed [glmd_pkg::VAL_W-1:0]   out_cell_out,
  output logic                                out_is_minimum,
  output logic                                out_frame_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [glmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [5:0]                          cfg_data
);

  logic [4:0]       row_last_r, col_last_r;
  logic [4:0]       row_pos_r, row_pos_nxt;
  logic [4:0]       col_pos_r, col_pos_nxt;
  logic             flush_r, flush_nxt;
  logic [4:0]       flush_row_r, flush_row_nxt;
  logic [4:0]       flush_col_r, flush_col_nxt;

  glmd_pkg::issue_t s1_r, s1_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  glmd_pkg::col_t   s2_r, s2_nxt;
  logic             s2_valid_r, s2_valid_nxt;

  logic             room, adv3, adv2, s1_free;
  logic             issue_in, issue_fl, cfg_we, in_last;
  logic [glmd_pkg::LINE_W-1:0] rd_data;
  glmd_pkg::push_t  push;

  // Stage handshakes
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready &&
                     ((cfg_index == glmd_pkg::REG_ROW_COUNT) ||
                      (cfg_index == glmd_pkg::REG_COL_COUNT));
  assign adv2      = s1_valid_r && (!s2_valid_r || adv3);
  assign s1_free   = !s1_valid_r || adv2;
  assign in_ready  = s1_free && !flush_r;
  assign issue_in  = in_valid && in_ready;
  assign issue_fl  = flush_r && s1_free;
  assign in_last   = (row_pos_r == row_last_r) && (col_pos_r == col_last_r);

  // Count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_last_r <= glmd_pkg::last_index(6'd32, glmd_pkg::ROW_CAP);
      col_last_r <= glmd_pkg::last_index(6'd32, glmd_pkg::COL_CAP);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == glmd_pkg::REG_ROW_COUNT) begin
        row_last_r <= glmd_pkg::last_index(cfg_data, glmd_pkg::ROW_CAP);
      end
      if (cfg_index == glmd_pkg::REG_COL_COUNT) begin
        col_last_r <= glmd_pkg::last_index(cfg_data, glmd_pkg::COL_CAP);
      end
    end
  end

  // Raster position, last-row pass and issue of beats to the line memory
  always_comb begin
    row_pos_nxt   = row_pos_r;
    col_pos_nxt   = col_pos_r;
    flush_nxt     = flush_r;
    flush_row_nxt = flush_row_r;
    flush_col_nxt = flush_col_r;
    s1_nxt        = s1_r;
    s1_valid_nxt  = adv2 ? 1'b0 : s1_valid_r;

    if (issue_in) begin
      s1_nxt.value     = in_cell_value;
      s1_nxt.row       = row_pos_r - 5'd1;
      s1_nxt.col       = col_pos_r;
      s1_nxt.has_top   = (row_pos_r >= 5'd2);
      s1_nxt.flush     = 1'b0;
      s1_nxt.emit      = (row_pos_r != 5'd0);
      s1_nxt.last_col  = (col_pos_r == col_last_r);
      s1_nxt.frame_end = 1'b0;
      s1_valid_nxt     = 1'b1;
      if (in_last) begin
        flush_nxt     = 1'b1;
        flush_row_nxt = row_pos_r;
        flush_col_nxt = 5'd0;
        row_pos_nxt   = 5'd0;
        col_pos_nxt   = 5'd0;
      end else if (col_pos_r == col_last_r) begin
        row_pos_nxt = row_pos_r + 5'd1;
        col_pos_nxt = 5'd0;
      end else begin
        col_pos_nxt = col_pos_r + 5'd1;
      end
    end else if (issue_fl) begin
      s1_nxt.value     = '0;
      s1_nxt.row       = flush_row_r;
      s1_nxt.col       = flush_col_r;
      s1_nxt.has_top   = (flush_row_r != 5'd0);
      s1_nxt.flush     = 1'b1;
      s1_nxt.emit      = 1'b1;
      s1_nxt.last_col  = (flush_col_r == col_last_r);
      s1_nxt.frame_end = (flush_col_r == col_last_r);
      s1_valid_nxt     = 1'b1;
      if (flush_col_r == col_last_r) begin
        flush_nxt = 1'b0;
      end else begin
        flush_col_nxt = flush_col_r + 5'd1;
      end
    end

    // Restart the frame on a register write
    if (cfg_we) begin
      row_pos_nxt = 5'd0;
      col_pos_nxt = 5'd0;
    end
  end

  // Form the window column from the memory read, hold while stalled
  always_comb begin
    s2_nxt       = s2_r;
    s2_valid_nxt = adv3 ? 1'b0 : s2_valid_r;
    if (adv2) begin
      s2_nxt.top       = rd_data[glmd_pkg::LINE_W-1:glmd_pkg::VAL_W];
      s2_nxt.ctr       = rd_data[glmd_pkg::VAL_W-1:0];
      s2_nxt.bot       = s1_r.value;
      s2_nxt.has_top   = s1_r.has_top;
      s2_nxt.has_bot   = !s1_r.flush;
      s2_nxt.emit      = s1_r.emit;
      s2_nxt.last_col  = s1_r.last_col;
      s2_nxt.frame_end = s1_r.frame_end;
      s2_nxt.row       = s1_r.row;
      s2_nxt.col       = s1_r.col;
      s2_valid_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r  <= 5'd0;
      col_pos_r  <= 5'd0;
      flush_r    <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      row_pos_r  <= row_pos_nxt;
      col_pos_r  <= col_pos_nxt;
      flush_r    <= flush_nxt;
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flush_row_r <= flush_row_nxt;
    flush_col_r <= flush_col_nxt;
    s1_r        <= s1_nxt;
    s2_r        <= s2_nxt;
  end

  // Line memory: read at issue, write back {previous row, new cell} on advance
  glmd_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (issue_in || issue_fl),
    .rd_addr (issue_in ? col_pos_r[glmd_pkg::LINE_AW-1:0]
                       : flush_col_r[glmd_pkg::LINE_AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (adv2 && !s1_r.flush),
    .wr_addr (s1_r.col[glmd_pkg::LINE_AW-1:0]),
    .wr_data ({rd_data[glmd_pkg::VAL_W-1:0], s1_r.value})
  );

  glmd_window u_window (
    .clk       (clk),
    .col_valid (s2_valid_r),
    .col_in    (s2_r),
    .room      (room),
    .adv       (adv3),
    .push      (push)
  );

  glmd_out_fifo u_out_fifo (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .room           (room),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_row   (out_cell_row),
    .out_cell_col   (out_cell_col),
    .out_cell_out   (out_cell_out),
    .out_is_minimum (out_is_minimum),
    .out_frame_end  (out_frame_end)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid local minimum detector. A table of
// directed beats covers the value extremes, zero counts, single rows and
// columns, equal neighbors, a restart by register write and writes to
// unused indexes. Random frames follow, mostly small, a few at the full
// width or height, some cut short, all with random content.
// Every result is checked field by field against an in-bench line buffer
// model, while both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          SETTLE_CYCLES = 48;
  localparam int          RANDOM_CELLS  = 200;
  localparam logic [1:0]  REG_SPARE_LO  = 2'd2;
  localparam logic [1:0]  REG_SPARE_HI  = 2'd3;

  typedef enum int {LINE_UPPER, LINE_MIDDLE, LINE_LOWER} line_sel_t;
  typedef enum int {STIM_CELL, STIM_CFG} stim_kind_t;

  typedef struct {
    stim_kind_t                        kind;
    logic [1:0]                        index;
    logic signed [glmd_pkg::VAL_W-1:0] data;
    bit                                typed;
    glmd_pkg::res_t                    result;
  } stim_row_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic signed [glmd_pkg::VAL_W-1:0] in_cell_value;
  logic                              out_valid;
  logic                              out_ready;
  logic [4:0]                        out_cell_row;
  logic [4:0]                        out_cell_col;
  logic signed [glmd_pkg::VAL_W-1:0] out_cell_out;
  logic                              out_is_minimum;
  logic                              out_frame_end;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [glmd_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [5:0]                        cfg_data;

  // Line buffer model: two rows above plus the row being filled
  logic signed [glmd_pkg::VAL_W-1:0] upper_row  [32];
  logic signed [glmd_pkg::VAL_W-1:0] middle_row [32];
  logic signed [glmd_pkg::VAL_W-1:0] lower_row  [32];
  int unsigned                       next_row;
  int unsigned                       next_col;
  logic [5:0]                        rows_reg;
  logic [5:0]                        cols_reg;

  glmd_pkg::res_t minima_due[$];
  glmd_pkg::res_t fresh_minima[$];
  stim_row_t      directed[$];

  bit          gaps_on;
  int unsigned cycle_count;
  int unsigned error_count  = 0;
  int unsigned cells_sent;
  int unsigned random_cells;
  int unsigned writes_done;
  int unsigned results_seen = 0;
  int unsigned frames_seen  = 0;

  grid_local_minimum_detector dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_row   (out_cell_row),
    .out_cell_col   (out_cell_col),
    .out_cell_out   (out_cell_out),
    .out_is_minimum (out_is_minimum),
    .out_frame_end  (out_frame_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles, give up at the limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Count register value to effective size, 0 counts as 1
  function automatic int unsigned clamp_count(input logic [5:0] v, input logic [5:0] cap);
    if (v == 6'd0) return 1;
    if (v > cap) return int'(cap);
    return int'(v);
  endfunction

  function automatic logic signed [glmd_pkg::VAL_W-1:0] line_at(input line_sel_t sel,
                                                                input int idx);
    case (sel)
      LINE_UPPER:  return upper_row[idx];
      LINE_MIDDLE: return middle_row[idx];
      default:     return lower_row[idx];
    endcase
  endfunction

  // True if h exceeds an existing entry of one line around column c
  function automatic bit above_line(input logic signed [glmd_pkg::VAL_W-1:0] h,
                                    input line_sel_t sel, input int c, input int n,
                                    input bit with_center);
    if (c >= 1 && h > line_at(sel, c - 1)) return 1'b1;
    if (with_center && h > line_at(sel, c)) return 1'b1;
    if (c + 1 < n && h > line_at(sel, c + 1)) return 1'b1;
    return 1'b0;
  endfunction

  task automatic classify_cell(input int r, input int c, input line_sel_t up,
                               input line_sel_t mid, input line_sel_t dn, input bit has_up,
                               input bit has_dn, input int n, input bit last);
    logic signed [glmd_pkg::VAL_W-1:0] h;
    bit                                beaten;
    glmd_pkg::res_t                    e;
    h      = line_at(mid, c);
    beaten = (has_up && above_line(h, up, c, n, 1'b1)) ||
             above_line(h, mid, c, n, 1'b0) ||
             (has_dn && above_line(h, dn, c, n, 1'b1));
    e.row       = 5'(r);
    e.col       = 5'(c);
    e.value     = h;
    e.is_min    = !beaten;
    e.frame_end = last;
    fresh_minima.push_back(e);
  endtask

  // Take one cell into the model; classified cells land in fresh_minima
  task automatic absorb_cell(input logic signed [glmd_pkg::VAL_W-1:0] v);
    int unsigned nr;
    int unsigned nc;
    int unsigned r;
    int unsigned c;
    bit          last;
    nr = clamp_count(rows_reg, glmd_pkg::ROW_CAP);
    nc = clamp_count(cols_reg, glmd_pkg::COL_CAP);
    r  = (next_row >= nr) ? nr - 1 : next_row;
    c  = (next_col >= nc) ? nc - 1 : next_col;
    last = (r == nr - 1) && (c == nc - 1);
    lower_row[c] = v;
    // Cells of the row above whose window just closed
    if (r >= 1) begin
      if (c >= 1) begin
        classify_cell(r - 1, c - 1, LINE_UPPER, LINE_MIDDLE, LINE_LOWER, r >= 2, 1'b1, nc,
                      1'b0);
      end
      if (c == nc - 1) begin
        classify_cell(r - 1, c, LINE_UPPER, LINE_MIDDLE, LINE_LOWER, r >= 2, 1'b1, nc, 1'b0);
      end
    end
    // Final cell: flush the last row and restart
    if (last) begin
      for (int j = 0; j < nc; j++) begin
        classify_cell(r, j, LINE_MIDDLE, LINE_LOWER, LINE_LOWER, r >= 1, 1'b0, nc,
                      j == nc - 1);
      end
      next_row = 0;
      next_col = 0;
    end else if (c == nc - 1) begin
      for (int j = 0; j < 32; j++) begin
        upper_row[j]  = middle_row[j];
        middle_row[j] = lower_row[j];
      end
      next_row = r + 1;
      next_col = 0;
    end else begin
      next_row = r;
      next_col = c + 1;
    end
  endtask

  task automatic apply_register(input logic [1:0] idx, input logic [5:0] data);
    if (idx == glmd_pkg::REG_ROW_COUNT) begin
      rows_reg = data;
    end else if (idx == glmd_pkg::REG_COL_COUNT) begin
      cols_reg = data;
    end else begin
      return;
    end
    next_row = 0;
    next_col = 0;
  endtask

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Drive one cell beat; expectations are booked as the beat is offered
  task automatic send_cell(input logic signed [glmd_pkg::VAL_W-1:0] v, input bit typed,
                           input glmd_pkg::res_t typed_result);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cell_value <= v;
    fresh_minima.delete();
    absorb_cell(v);
    if (typed) begin
      minima_due.push_back(typed_result);
    end else begin
      foreach (fresh_minima[i]) minima_due.push_back(fresh_minima[i]);
    end
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cells_sent++;
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [5:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    apply_register(idx, data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    writes_done++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the input until every booked result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (minima_due.size() != 0) @(posedge clk);
  endtask

  // Drained, then let any flush or row-0 beats finish inside the block
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [glmd_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2, 3, 4: return glmd_pkg::VAL_W'(int'($urandom_range(0, 6)) - 3);
      default: return $urandom();
    endcase
  endfunction

  task automatic dir_cfg(input logic [1:0] idx, input logic [5:0] data);
    stim_row_t s;
    s.kind   = STIM_CFG;
    s.index  = idx;
    s.data   = glmd_pkg::VAL_W'(data);
    s.typed  = 1'b0;
    s.result = '0;
    directed.push_back(s);
  endtask

  task automatic dir_cell(input logic signed [glmd_pkg::VAL_W-1:0] v);
    stim_row_t s;
    s.kind   = STIM_CELL;
    s.index  = glmd_pkg::REG_ROW_COUNT;
    s.data   = v;
    s.typed  = 1'b0;
    s.result = '0;
    directed.push_back(s);
  endtask

  // 1x1 frame: the lone cell is its own minimum and ends the frame
  task automatic dir_lone_cell(input logic signed [glmd_pkg::VAL_W-1:0] v);
    stim_row_t s;
    s.kind             = STIM_CELL;
    s.index            = glmd_pkg::REG_ROW_COUNT;
    s.data             = v;
    s.typed            = 1'b1;
    s.result.row       = 5'd0;
    s.result.col       = 5'd0;
    s.result.value     = v;
    s.result.is_min    = 1'b1;
    s.result.frame_end = 1'b1;
    directed.push_back(s);
  endtask

  task automatic run_directed();
    // 1x1 frames at the value extremes, then zero counts
    dir_cfg(glmd_pkg::REG_ROW_COUNT, 6'd1);
    dir_cfg(glmd_pkg::REG_COL_COUNT, 6'd1);
    dir_lone_cell(32'sh8000_0000);
    dir_lone_cell(32'sh7FFF_FFFF);
    dir_cfg(glmd_pkg::REG_ROW_COUNT, 6'd0);
    dir_cfg(glmd_pkg::REG_COL_COUNT, 6'd0);
    dir_lone_cell(32'sh0);
    // 2x3 frame with extremes next to each other
    dir_cfg(glmd_pkg::REG_ROW_COUNT, 6'd2);
    dir_cfg(glmd_pkg::REG_COL_COUNT, 6'd3);
    dir_cell(32'sh7FFF_FFFF);
    dir_cell(32'sh8000_0000);
    dir_cell(32'sh3);
    dir_cell(-32'sh1);
    dir_cell(32'sh3);
    dir_cell(32'sh7FFF_FFFF);
    // Single row, unused index written mid-frame must not restart it
    dir_cfg(glmd_pkg::REG_ROW_COUNT, 6'd1);
    dir_cfg(glmd_pkg::REG_COL_COUNT, 6'd4);
    dir_cell(32'sh2);
    dir_cell(32'sh2);
    dir_cfg(REG_SPARE_LO, 6'd1);
    dir_cell(32'sh1);
    dir_cell(32'sh2);
    // Partial frame, then a rewrite restarts; equal cells are all minima
    dir_cfg(glmd_pkg::REG_ROW_COUNT, 6'd3);
    dir_cfg(glmd_pkg::REG_COL_COUNT, 6'd2);
    dir_cell(32'sh9);
    dir_cell(32'sh8);
    dir_cfg(glmd_pkg::REG_COL_COUNT, 6'd2);
    repeat (6) dir_cell(32'sh4);

    foreach (directed[i]) begin
      if (directed[i].kind == STIM_CFG) begin
        settle();
        write_register(directed[i].index, directed[i].data[5:0]);
      end else begin
        send_cell(directed[i].data, directed[i].typed, directed[i].result);
      end
    end
  endtask

  task automatic run_random_frames();
    int unsigned shape;
    int unsigned total;
    int unsigned cut;
    int unsigned spare_at;
    int unsigned pause_at;
    logic [5:0]  rows_raw;
    logic [5:0]  cols_raw;
    shape = 0;
    while (random_cells < RANDOM_CELLS) begin
      gaps_on = !(random_cells >= 60 && random_cells < 130);
      // First the tallest and widest frames, then mostly small ones
      rows_raw = 6'($urandom_range(1, 5));
      cols_raw = 6'($urandom_range(1, 6));
      case (shape)
        0: begin
          rows_raw = 6'd63;
          cols_raw = 6'd1;
        end
        1: begin
          rows_raw = 6'd1;
          cols_raw = 6'd40;
        end
        default: begin
          case ($urandom_range(0, 11))
            0: rows_raw = 6'd0;
            1: begin
              rows_raw = 6'($urandom_range(32, 63));
              cols_raw = 6'($urandom_range(1, 2));
            end
            2: cols_raw = 6'd0;
            3: begin
              cols_raw = 6'($urandom_range(32, 63));
              rows_raw = 6'($urandom_range(1, 2));
            end
            default: ;
          endcase
        end
      endcase
      shape++;
      settle();
      write_register(glmd_pkg::REG_ROW_COUNT, rows_raw);
      write_register(glmd_pkg::REG_COL_COUNT, cols_raw);
      total    = clamp_count(rows_raw, glmd_pkg::ROW_CAP) *
                 clamp_count(cols_raw, glmd_pkg::COL_CAP);
      cut      = (total > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : total;
      spare_at = (total > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, total - 1) : 0;
      pause_at = (total > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, total - 1) : 0;
      for (int unsigned k = 0; k < cut; k++) begin
        if (k != 0 && k == spare_at) begin
          settle();
          write_register($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 6'($urandom()));
        end
        if (k != 0 && k == pause_at) wait_drained();
        send_cell(pick_value(), 1'b0, '0);
        random_cells++;
      end
    end
    gaps_on = 1'b1;
  endtask

  // Result side: random back-pressure
  always @(negedge clk) begin
    out_ready <= !(gaps_on && $urandom_range(0, 99) < 21);
  end

  // Check each result beat against the oldest booked one
  always @(posedge clk) begin
    glmd_pkg::res_t got;
    glmd_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      got.row       = out_cell_row;
      got.col       = out_cell_col;
      got.value     = out_cell_out;
      got.is_min    = out_is_minimum;
      got.frame_end = out_frame_end;
      results_seen++;
      if (got.frame_end === 1'b1) frames_seen++;
      if (minima_due.size() == 0) begin
        flag_error($sformatf("unexpected result row %0d col %0d value %0d min %b end %b",
                             got.row, got.col, got.value, got.is_min, got.frame_end));
      end else begin
        want = minima_due.pop_front();
        if (got.row !== want.row || got.col !== want.col || got.value !== want.value ||
            got.is_min !== want.is_min || got.frame_end !== want.frame_end) begin
          flag_error($sformatf({"result mismatch: expected row %0d col %0d value %0d ",
                                "min %b end %b, got row %0d col %0d value %0d min %b end %b"},
                               want.row, want.col, want.value, want.is_min, want.frame_end,
                               got.row, got.col, got.value, got.is_min, got.frame_end));
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cell_value = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    gaps_on       = 1'b1;
    cells_sent    = 0;
    random_cells  = 0;
    writes_done   = 0;
    for (int j = 0; j < 32; j++) begin
      upper_row[j]  = '0;
      middle_row[j] = '0;
      lower_row[j]  = '0;
    end
    next_row = 0;
    next_col = 0;
    rows_reg = 6'd32;
    cols_reg = 6'd32;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random_frames();

    // Drain, then give the block time to show any stray beat
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d cells and %0d register writes; checked %0d results in %0d frames.",
             cells_sent, writes_done, results_seen, frames_seen);
    $display("Frames ranged from 1x1 to 32 rows or 32 columns, with restarts and cut frames.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/glmd_pkg.sv
hw/rtl/glmd_line_mem.sv
hw/rtl/glmd_window.sv
hw/rtl/glmd_out_fifo.sv
hw/rtl/grid_local_minimum_detector.sv
verif/tb.sv
